FILE: hw/rtl/text_console_writer_macros.svh
// ---------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_console_writer check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_console_writer check failed");

`else

`define TCW_ASSERT_NOW(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// Text console writer package
// Screen geometry, request codes, control characters and register indexes.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int CELLS   = 2000;

    localparam int CUR_W = 11;
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam int LAST_ROW_INT = (CELLS > COLUMNS) ? (CELLS - COLUMNS) : 0;
    localparam int LAST_COL_INT = LAST_ROW_INT % COLUMNS;

    typedef logic [CUR_W-1:0] cur_t;
    typedef logic [COL_W-1:0] col_t;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic CFG_DEFAULT_COLOR = 1'b0;
    localparam logic CFG_BLANK_ATTR    = 1'b1;

    localparam logic [7:0] DEFAULT_COLOR_RST = 8'd7;
    localparam logic [7:0] BLANK_ATTR_RST    = 8'd15;

    localparam logic [1:0] TAB_LAST = 2'd3;

endpackage

FILE: hw/rtl/text_console_writer.sv
// Put steps S_PUT then S_DONE; read S_READ then S_DONE (an index past the end
// skips S_READ); an unknown request goes to S_DONE. A put that passes the
// screen end adds the scroll walk (copy plus last-row blank through the one
// read and one write port of the screen memory); a tab is four puts in turn.
// Clear blanks all cells. One request at a time: the next awaits the result.
// Reset: cursor 0, registers to defaults; screen memory is not cleared.
// ---------------------------------------------------------------------------
// Text console writer
// Keeps a text screen in one synchronous memory plus a cursor; handles put,
// read and clear requests with scroll on overflow.
// ---------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module text_console_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [7:0]  char_color,
    input  logic [10:0] cell_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] cursor_pos,
    output logic [15:0] cell_value,
    output logic        scrolled,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam int CW = tcw_pkg::CUR_W;
    localparam int LW = tcw_pkg::COL_W;

    localparam logic [CW:0]   CELLS_X    = (CW + 1)'(tcw_pkg::CELLS);
    localparam logic [CW:0]   COLUMNS_X  = (CW + 1)'(tcw_pkg::COLUMNS);
    localparam logic [CW-1:0] CELLS_C    = CW'(tcw_pkg::CELLS);
    localparam logic [CW-1:0] LAST_CELL  = CW'(tcw_pkg::CELLS - 1);
    localparam logic [CW-1:0] COLUMNS_C  = CW'(tcw_pkg::COLUMNS);
    localparam logic [CW-1:0] LAST_ROW   = CW'(tcw_pkg::LAST_ROW_INT);
    localparam logic [LW-1:0] LAST_COL   = LW'(tcw_pkg::LAST_COL_INT);
    localparam logic [LW:0]   COLUMNS_L  = (LW + 1)'(tcw_pkg::COLUMNS);

    // screen memory
    logic [15:0] screen_mem [tcw_pkg::CELLS];
    logic [15:0] mem_rdata_reg;
    logic        mem_we;
    logic [CW-1:0] mem_waddr;
    logic [15:0] mem_wdata;
    logic [CW-1:0] mem_raddr;

    // control
    logic [2:0]      state_reg, state_next;
    tcw_pkg::cur_t   cursor_reg, cursor_next;
    tcw_pkg::col_t   col_reg, col_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic            pend_reg, pend_next;
    logic [1:0]      tab_cnt_reg, tab_cnt_next;
    logic            more_reg, more_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      default_color_reg;
    logic [7:0]      blank_attr_reg;

    // payload
    logic [7:0]      ch_reg, ch_next;
    logic [7:0]      color_reg, color_next;
    logic [15:0]     val_reg, val_next;
    logic            roll_reg, roll_next;
    logic [CW-1:0]   cursor_pos_reg, cursor_pos_next;
    logic [15:0]     cell_value_reg, cell_value_next;
    logic            scrolled_reg, scrolled_next;

    logic            is_tab;
    logic [7:0]      put_ch;
    logic [7:0]      put_color;
    logic [CW:0]     c_wide;
    tcw_pkg::col_t   col_new;
    logic [LW:0]     col_inc;
    logic [15:0]     blank_cell;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_value = cell_value_reg;
    assign scrolled   = scrolled_reg;

    assign blank_cell = {blank_attr_reg, tcw_pkg::CH_SPACE};
    assign is_tab     = (ch_reg == tcw_pkg::CH_TAB);
    assign put_ch     = is_tab ? tcw_pkg::CH_SPACE : ch_reg;
    assign put_color  = is_tab ? default_color_reg : color_reg;
    assign col_inc    = {1'b0, col_reg} + (LW + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= screen_mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        tab_cnt_next    = tab_cnt_reg;
        more_next       = more_reg;
        out_valid_next  = out_valid_reg;
        ch_next         = ch_reg;
        color_next      = color_reg;
        val_next        = val_reg;
        roll_next       = roll_reg;
        cursor_pos_next = cursor_pos_reg;
        cell_value_next = cell_value_reg;
        scrolled_next   = scrolled_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = blank_cell;
        mem_raddr       = cell_index;
        c_wide          = {1'b0, cursor_reg};
        col_new         = col_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next      = char_code;
                    color_next   = char_color;
                    val_next     = 16'd0;
                    roll_next    = 1'b0;
                    tab_cnt_next = 2'd0;
                    more_next    = 1'b0;
                    case (req_type)
                        tcw_pkg::REQ_PUT:
                        begin
                            state_next = S_PUT;
                        end
                        tcw_pkg::REQ_READ:
                        begin
                            state_next = (cell_index < CELLS_C) ? S_READ : S_DONE;
                        end
                        tcw_pkg::REQ_CLEAR:
                        begin
                            ptr_next    = '0;
                            cursor_next = '0;
                            col_next    = '0;
                            state_next  = S_BLANK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                case (put_ch)
                    tcw_pkg::CH_LF:
                    begin
                        c_wide  = {1'b0, cursor_reg} - (CW + 1)'(col_reg) + COLUMNS_X;
                        col_new = '0;
                    end
                    tcw_pkg::CH_CR:
                    begin
                        c_wide  = {1'b0, cursor_reg} - (CW + 1)'(col_reg);
                        col_new = '0;
                    end
                    tcw_pkg::CH_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            c_wide  = {1'b0, cursor_reg} - (CW + 1)'(1);
                            col_new = col_reg - LW'(1);
                        end
                    end
                    default:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_reg;
                        mem_wdata = {put_color, put_ch};
                        c_wide    = {1'b0, cursor_reg} + (CW + 1)'(1);
                        col_new   = (col_inc == COLUMNS_L) ? '0 : col_inc[LW-1:0];
                    end
                endcase

                tab_cnt_next = tab_cnt_reg + 2'd1;
                more_next    = is_tab && (tab_cnt_reg != tcw_pkg::TAB_LAST);

                if (c_wide >= CELLS_X)
                begin
                    // advance into scroll: move rows up, then blank the last row
                    cursor_next = LAST_ROW;
                    col_next    = LAST_COL;
                    roll_next   = 1'b1;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCROLL;
                end
                else
                begin
                    cursor_next = c_wide[CW-1:0];
                    col_next    = col_new;
                    state_next  = (is_tab && (tab_cnt_reg != tcw_pkg::TAB_LAST)) ?
                                  S_PUT : S_DONE;
                end
            end

            S_SCROLL:
            begin
                mem_raddr = ptr_reg + COLUMNS_C;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - CW'(1);
                    mem_wdata = mem_rdata_reg;
                end
                if (ptr_reg < LAST_ROW)
                begin
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_BLANK;
                end
            end

            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = blank_cell;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = more_reg ? S_PUT : S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            S_READ:
            begin
                val_next   = mem_rdata_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    cursor_pos_next = cursor_reg;
                    cell_value_next = val_reg;
                    scrolled_next   = roll_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            tab_cnt_reg   <= 2'd0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            tab_cnt_reg   <= tab_cnt_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= tcw_pkg::DEFAULT_COLOR_RST;
            blank_attr_reg    <= tcw_pkg::BLANK_ATTR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tcw_pkg::CFG_DEFAULT_COLOR: default_color_reg <= cfg_data;
                tcw_pkg::CFG_BLANK_ATTR:    blank_attr_reg    <= cfg_data;
                default:                    blank_attr_reg    <= blank_attr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        color_reg      <= color_next;
        val_reg        <= val_next;
        roll_reg       <= roll_next;
        cursor_pos_reg <= cursor_pos_next;
        cell_value_reg <= cell_value_next;
        scrolled_reg   <= scrolled_next;
    end

    `TCW_ASSERT_NOW(a_cursor_in_screen, state_reg == S_IDLE, cursor_reg < CELLS_C)
    `TCW_ASSERT_NOW(a_col_in_row, 1'b1, {1'b0, col_reg} < COLUMNS_L)
    `TCW_ASSERT_NOW(a_write_in_screen, mem_we, mem_waddr < CELLS_C)
    `TCW_ASSERT_NEXT(a_done_delivers, state_reg == S_DONE && !(out_valid_reg && out_stall),
                     out_valid_reg && state_reg == S_IDLE)
    `TCW_ASSERT_NEXT(a_scroll_homes, state_reg == S_PUT && state_next == S_SCROLL,
                     cursor_reg == LAST_ROW && col_reg == LAST_COL && roll_reg)

endmodule

FILE: tb/text_console_writer_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Text console writer checker
// Watches the register port and both transaction channels, keeps its own
// copy of the screen, cursor and colors, predicts one result per accepted
// request and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module text_console_writer_checker
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [7:0]  char_color,
    input  logic [10:0] cell_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [10:0] cursor_pos,
    input  logic [15:0] cell_value,
    input  logic        scrolled,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          errors,
    output int          outstanding,
    output int          scroll_count
);

    typedef struct packed {
        logic [10:0] cursor;
        logic [15:0] cell_word;
        logic        scrolled;
    } console_result_t;

    logic [15:0]     screen [CELLS];
    cur_t            cursor;
    logic [7:0]      tab_attr;
    logic [7:0]      blank_attr;
    console_result_t pending_q [$];
    console_result_t want;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [15:0] blank_cell();
        return {blank_attr, CH_SPACE};
    endfunction

    // one character step of the cursor; returns 1 when the screen rolled up
    function automatic logic advance(input logic [7:0] attr, input logic [7:0] ch);
        int c;
        int i;
        c = int'(cursor);
        case (ch)
            CH_LF:
            begin
                c = c + COLUMNS;
                c = c - c % COLUMNS;
            end
            CH_CR:
            begin
                c = c - c % COLUMNS;
            end
            CH_BS:
            begin
                if (c % COLUMNS != 0)
                    c = c - 1;
            end
            default:
            begin
                if (c < CELLS)
                    screen[c] = {attr, ch};
                c = c + 1;
            end
        endcase
        if (c >= CELLS)
        begin
            for (i = 0; i < LAST_ROW_INT; i++)
                screen[i] = screen[i + COLUMNS];
            for (i = LAST_ROW_INT; i < CELLS; i++)
                screen[i] = blank_cell();
            cursor = cur_t'(LAST_ROW_INT);
            return 1'b1;
        end
        cursor = cur_t'(c);
        return 1'b0;
    endfunction

    function automatic console_result_t console_response(input logic [1:0] req,
                                                         input logic [7:0] ch,
                                                         input logic [7:0] attr,
                                                         input logic [10:0] idx);
        console_result_t r;
        int k;
        r = '0;
        case (req)
            REQ_PUT:
            begin
                if (ch == CH_TAB)
                begin
                    for (k = 0; k < 4; k++)
                        if (advance(tab_attr, CH_SPACE))
                            r.scrolled = 1'b1;
                end
                else
                begin
                    r.scrolled = advance(attr, ch);
                end
            end
            REQ_READ:
            begin
                if (idx < CELLS)
                    r.cell_word = screen[idx];
            end
            REQ_CLEAR:
            begin
                for (k = 0; k < CELLS; k++)
                    screen[k] = blank_cell();
                cursor = '0;
            end
            default:
            begin
            end
        endcase
        r.cursor = cursor;
        if (r.scrolled)
            scroll_count++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor     = '0;
            tab_attr   = DEFAULT_COLOR_RST;
            blank_attr = BLANK_ATTR_RST;
            pending_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_DEFAULT_COLOR)
                    tab_attr = cfg_data;
                else
                    blank_attr = cfg_data;
            end
            if (in_valid && !in_stall)
                pending_q.push_back(console_response(req_type, char_code, char_color,
                                                     cell_index));
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    report_mismatch($sformatf("unrequested result cursor %0d cell %h",
                                              cursor_pos, cell_value));
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (cursor_pos !== want.cursor)
                        report_mismatch($sformatf("cursor_pos %0d, want %0d",
                                                  cursor_pos, want.cursor));
                    if (cell_value !== want.cell_word)
                        report_mismatch($sformatf("cell_value %h, want %h",
                                                  cell_value, want.cell_word));
                    if (scrolled !== want.scrolled)
                        report_mismatch($sformatf("scrolled %b, want %b",
                                                  scrolled, want.scrolled));
                end
            end
        end
        outstanding = pending_q.size();
    end

endmodule

FILE: tb/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Text console writer testbench
// Drives put, read, clear and unknown requests with random gaps and output
// stalls under several color settings; a directed opening covers control
// codes and edge values, then a weighted random stream reaches scrolling.
// ---------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int LIMIT            = 4_000_000;
    localparam int LONG_HOLD        = 150;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [7:0] TAB_SET   [PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h07, 8'h5A};
    localparam logic [7:0] BLANK_SET [PHASES] = '{8'h00, 8'hFF, 8'hFF, 8'h0F, 8'hA5};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  char_color;
    logic [10:0] cell_index;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
    logic        cfg_write;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    int errors;
    int outstanding;
    int scroll_count;
    int cycles = 0;
    int n_puts = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_unknown = 0;
    bit calm = 1'b0;
    bit hold_drain = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    text_console_writer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .char_color (char_color),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_pos (cursor_pos),
        .cell_value (cell_value),
        .scrolled   (scrolled),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    text_console_writer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .char_code    (char_code),
        .char_color   (char_color),
        .cell_index   (cell_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_pos   (cursor_pos),
        .cell_value   (cell_value),
        .scrolled     (scrolled),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding),
        .scroll_count (scroll_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending", cycles, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // stall the result channel for a random time after a transaction; hold long on request
    initial
    begin : drain_side
        int pause;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                pause = calm ? 0 : $urandom_range(0, 17);
                if (hold_drain)
                begin
                    pause = LONG_HOLD;
                    hold_drain = 1'b0;
                end
                if (pause > 0)
                begin
                    @(negedge clk) out_stall <= 1'b1;
                    repeat (pause - 1) @(negedge clk);
                    @(negedge clk) out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                                input logic [7:0] attr, input logic [10:0] idx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        char_code  <= ch;
        char_color <= attr;
        cell_index <= idx;
        do @(posedge clk); while (in_stall);
        case (req)
            REQ_PUT:   n_puts++;
            REQ_READ:  n_reads++;
            REQ_CLEAR: n_clears++;
            default:   n_unknown++;
        endcase
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk) in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    initial
    begin : stimulus
        int ph;
        int sent;
        int pick;
        logic [1:0]  req;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic [7:0]  tab_c;
        logic [7:0]  blank_c;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_PUT;
        char_code  = '0;
        char_color = '0;
        cell_index = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_DEFAULT_COLOR;
        cfg_data   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        write_reg(CFG_DEFAULT_COLOR, 8'h4E);
        write_reg(CFG_BLANK_ATTR, 8'h1F);

        // only written or cleared cells are read before the first clear
        send_request(REQ_PUT, 8'h41, 8'h1E, 11'd0);
        send_request(REQ_READ, 8'h00, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 8'h00, 11'h7FF);
        send_request(REQ_READ, 8'hFF, 8'hFF, 11'(CELLS));
        send_request(REQ_UNKNOWN, 8'hFF, 8'hFF, 11'h7FF);
        send_request(REQ_CLEAR, 8'h00, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 8'h00, 11'(CELLS - 1));
        send_request(REQ_PUT, CH_BS, 8'h00, 11'd0);
        send_request(REQ_PUT, 8'h00, 8'h00, 11'd0);
        send_request(REQ_PUT, 8'hFF, 8'hFF, 11'h7FF);
        send_request(REQ_PUT, CH_BS, 8'h00, 11'd0);
        send_request(REQ_PUT, CH_TAB, 8'hC3, 11'd0);
        send_request(REQ_READ, 8'h00, 8'h00, 11'd1);
        send_request(REQ_READ, 8'h00, 8'h00, 11'd4);
        send_request(REQ_PUT, CH_CR, 8'h00, 11'd0);
        send_request(REQ_PUT, CH_LF, 8'h00, 11'd0);
        send_request(REQ_PUT, 8'h5A, 8'hC3, 11'd0);
        send_request(REQ_READ, 8'h00, 8'h00, 11'(COLUMNS));
        send_request(REQ_READ, 8'h00, 8'h00, 11'd0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            tab_c   = (ph == 3) ? 8'($urandom) : TAB_SET[ph];
            blank_c = (ph == 3) ? 8'($urandom) : BLANK_SET[ph];
            write_reg(CFG_DEFAULT_COLOR, tab_c);
            write_reg(CFG_BLANK_ATTR, blank_c);
            if (ph == 1)
                hold_drain = 1'b1;
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                if (sent % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 999);
                ch   = 8'($urandom);
                idx  = 11'($urandom_range(0, CELLS - 1));
                if (pick < 700)
                begin
                    req  = REQ_PUT;
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        ch = CH_LF;
                    else if (pick < 20)
                        ch = CH_CR;
                    else if (pick < 28)
                        ch = CH_BS;
                    else if (pick < 36)
                        ch = CH_TAB;
                end
                else if (pick < 975)
                begin
                    req = REQ_READ;
                    if ($urandom_range(0, 9) == 0)
                        idx = 11'($urandom_range(CELLS, 2047));
                end
                else if (pick < 980)
                begin
                    req = REQ_CLEAR;
                end
                else
                begin
                    req = REQ_UNKNOWN;
                end
                send_request(req, ch, 8'($urandom), idx);
                if (req != REQ_UNKNOWN)
                    sent++;
            end
        end

        wait_idle();
        repeat (32) @(posedge clk);
        $display("Covered %0d puts, %0d reads, %0d clears and %0d unknown requests",
                 n_puts, n_reads, n_clears, n_unknown);
        $display("with %0d scrolls across %0d color settings in %0d cycles",
                 scroll_count, PHASES + 1, cycles);
        if (errors == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
